[rtl/sha_pkg.sv]
// SHA-256 hasher package: round constants, initial hash values, the shared item type.
// No dependencies.
package sha_pkg;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // one classified item handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_item;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/sha256_stream_hasher_core.sv]
// SHA-256 byte-stream hasher, top level. Depends on sha_pkg, sha_front, sha_back.
// Throughput: one byte a cycle into a 4-entry queue while it has room; a full block then
// runs the load, round and add states (one round a cycle) while input backs up.
// Closing block: pad pass plus load, rounds and add; the first digest word is valid after
// that (after an extra block when the message ends on a full block or needs two pad blocks).
// Reset (synchronous, active low) restores initial hash values and empties the queue.
module sha256_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // byte_valid
    input  logic        s_axis_tlast,  // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata, // [31:0] digest_word
    output logic [2:0]  m_axis_tuser, // [2:0] word_index
    output logic        m_axis_tlast  // last_word
);
    sha_pkg::t_item in_item, q_item;
    logic q_valid, q_pop;

    assign in_item = '{data_byte: s_axis_tdata, byte_valid: s_axis_tuser,
                       last: s_axis_tlast};

    sha_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item(in_item), .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item));

    sha_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_word(m_axis_tdata),
        .o_index(m_axis_tuser), .o_last(m_axis_tlast));
endmodule

[rtl/sha_front.sv]
// Front end: accepts bytes, drops empty items, queues the rest in a small FIFO.
// Depends on sha_pkg.
module sha_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sha_pkg::t_item i_item,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output sha_pkg::t_item o_q_item
);
    sha_pkg::t_item r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_ready   = (r_cnt != 3'd4);
    assign push      = i_valid && o_ready && (i_item.byte_valid || i_item.last);
    assign pop       = i_q_pop && (r_cnt != 3'd0);
    assign o_q_valid = (r_cnt != 3'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0) |-> !pop) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop && r_cnt != 3'd4) |=> r_cnt == $past(r_cnt) + 3'd1)
        else $error("count slip");
endmodule

[rtl/sha_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/sha_back.sv]
// Back end: buffers the block, pads, runs 64 rounds one per cycle, emits digest.
// Depends on sha_pkg and sha_ram.
module sha_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  sha_pkg::t_item i_q_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_word,
    output logic [2:0]     o_index,
    output logic           o_last
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,  // write padding bytes into the buffer
        S_LOAD  = 7'b0000100,  // read 64 bytes into the schedule window
        S_ROUND = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state      r_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_total;
    logic [6:0]  r_cnt;
    logic        r_final, r_second;
    logic [7:0]  pad_byte;
    logic        we;
    logic [5:0]  waddr, raddr;
    logic [7:0]  wdata, rdata;
    logic [5:0]  ld_pos;
    logic [31:0] big0, big1, ch, maj, t1, t2, s0, s1, w_new, w_cur;

    sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata));

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign raddr   = r_cnt[5:0];
    // byte position captured this load cycle (read data is registered, so it belongs to the previous address)
    assign ld_pos  = r_cnt[5:0] - 6'd1;

    // padding byte at r_cnt: 0x80 at fill, length in 56..63 of the closing block
    always_comb begin
        pad_byte = '0;
        if (!r_second && r_cnt[5:0] == r_fill) pad_byte = sha_pkg::PAD_BYTE;
        else if (r_cnt[5:0] >= 6'd56 && (r_second || r_fill < 6'd56))
            pad_byte = r_total[6'd63 - {r_cnt[2:0], 3'd0} -: 8];
    end

    always_comb begin
        we = 1'b0; waddr = r_fill; wdata = i_q_item.data_byte;
        if (o_q_pop && i_q_item.byte_valid) we = 1'b1;
        else if (r_state == S_PAD &&
                 (r_second || r_cnt[5:0] >= r_fill)) begin
            we = 1'b1; waddr = r_cnt[5:0]; wdata = pad_byte;
        end
    end

    always_comb begin
        w_cur = r_w[0];
        s0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        big1 = sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
             ^ sha_pkg::rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1   = r_v[7] + big1 + ch + sha_pkg::K_ROUND[r_cnt[5:0]] + w_cur;
        big0 = sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
             ^ sha_pkg::rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2   = big0 + maj;
    end

    assign o_valid = (r_state == S_OUT);
    assign o_word  = r_h[r_cnt[2:0]];
    assign o_index = r_cnt[2:0];
    assign o_last  = (r_cnt[2:0] == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fill <= '0; r_bits <= '0; r_cnt <= '0;
            r_final <= 1'b0; r_second <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::H_INIT[i];
        end else begin
            case (r_state)
                S_IDLE: if (o_q_pop) begin
                    r_cnt <= '0;
                    r_second <= 1'b0;
                    r_final <= 1'b0;
                    if (i_q_item.byte_valid) begin
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            // byte fills the block; if it is the last byte, r_bits stays behind so
                            // r_total != r_bits owes a fresh pad block afterwards
                            if (!i_q_item.last) r_bits <= r_bits + 64'd512;
                            r_total <= r_bits + 64'd512;
                            r_state <= S_LOAD;
                        end else if (i_q_item.last) begin
                            r_total <= r_bits + {55'd0, r_fill + 6'd1, 3'd0};
                            r_state <= S_PAD;
                        end
                    end else begin
                        r_total <= r_bits + {55'd0, r_fill, 3'd0};
                        r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    if (r_cnt[5:0] == 6'd63) begin
                        r_cnt <= '0;
                        r_final <= r_second || (r_fill < 6'd56);
                        r_state <= S_LOAD;
                    end else r_cnt <= r_cnt + 7'd1;
                end
                S_LOAD: begin
                    if (r_cnt != 7'd0)
                        r_w[ld_pos[5:2]] <= {r_w[ld_pos[5:2]][23:0], rdata};
                    if (r_cnt == 7'd64) begin
                        r_cnt <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_state <= S_ROUND;
                    end else r_cnt <= r_cnt + 7'd1;
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= w_new;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_cnt <= '0;
                    if (r_final) r_state <= S_OUT;
                    else if (r_second || r_fill != 6'd0) begin
                        r_second <= 1'b1;
                        r_state  <= S_PAD;
                    end else if (r_total != r_bits) r_state <= S_PAD;
                    else r_state <= S_IDLE;
                end
                S_OUT: if (i_ready) begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt[2:0] == 3'd7) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_fill <= '0; r_bits <= '0; r_cnt <= '0;
                    for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::H_INIT[i];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == S_IDLE) else $error("pop while busy");
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_cnt == 7'd63) |=> r_state == S_ADD)
        else $error("round count slip");
endmodule

[test/sha256_stream_hasher_core_tb.sv]
// Testbench for sha256_stream_hasher_core: byte stream in, digest words out.
// Depends on sha_pkg (round constants, initial hash values) and the RTL only.
// Holds its own SHA-256 digest predictor and a scoreboard of pending words.
`timescale 1ns / 100ps

class digest_board;
    logic [31:0] chain   [8];
    logic [7:0]  blk_buf [64];
    int unsigned blk_fill;
    logic [63:0] msg_bits;
    logic [31:0] exp_word [$];
    logic [2:0]  exp_idx  [$];
    logic        exp_last [$];
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned digests;

    function new();
        mismatches = 0;
        words_seen = 0;
        digests = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) chain[i] = sha_pkg::H_INIT[i];
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    static function logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void crunch(logic [7:0] b [64]);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K_ROUND[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // accepted input transaction
    function void note_byte(logic [7:0] d, logic bv, logic lst);
        logic [7:0] pad [64];
        logic [63:0] total;
        if (bv) begin
            blk_buf[blk_fill] = d;
            blk_fill++;
            if (blk_fill == 64) begin
                crunch(blk_buf);
                msg_bits += 64'd512;
                blk_fill = 0;
            end
        end
        if (!lst) return;
        total = msg_bits + 64'(blk_fill * 8);
        for (int i = 0; i < 64; i++) pad[i] = (i < blk_fill) ? blk_buf[i] : 8'h00;
        pad[blk_fill] = 8'h80;
        if (blk_fill + 1 > 56) begin
            crunch(pad);
            for (int i = 0; i < 64; i++) pad[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) pad[56+i] = total[63-8*i -: 8];
        crunch(pad);
        for (int i = 0; i < 8; i++) begin
            exp_word.push_back(chain[i]);
            exp_idx.push_back(3'(i));
            exp_last.push_back(i == 7);
        end
        digests++;
        restart();
    endfunction

    function void check_word(logic [31:0] w, logic [2:0] idx, logic lst);
        logic [31:0] ew;
        logic [2:0]  ei;
        logic        el;
        words_seen++;
        if (exp_word.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest word %h idx %0d", w, idx);
            return;
        end
        ew = exp_word.pop_front();
        ei = exp_idx.pop_front();
        el = exp_last.pop_front();
        if (w !== ew || idx !== ei || lst !== el) begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                         ew, ei, el, w, idx, lst);
        end
    endfunction

    function int pending();
        return exp_word.size();
    endfunction
endclass

module sha256_stream_hasher_core_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;  // byte_valid
    logic        s_axis_tlast = 1'b0;  // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] digest_word
    logic [2:0]  m_axis_tuser;         // [2:0] word_index
    logic        m_axis_tlast;         // last_word

    digest_board board = new();
    int  send_idle = 28;
    int  recv_idle = 53;
    bit  hold_off = 1'b0;
    int  items_sent = 0;
    longint cycles = 0;

    sha256_stream_hasher_core uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: sample and check, then choose tready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // one transaction, with random idle cycles ahead of it; tvalid stays up after it
    task automatic send_byte(logic [7:0] d, logic bv, logic lst);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= bv;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_byte(d, bv, lst);
        items_sent++;
    endtask

    task automatic stop_send();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_message(int len, bit empty_end);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom), 1'b1, !empty_end && i == len - 1);
        if (empty_end || len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    initial begin
        int len;
        bit ee;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, field extremes, ignored item, short messages
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h5a, 1'b0, 1'b0);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'haa, 1'b1, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        send_message(3, 1'b0);
        stop_send();
        drain();

        // sender keeps offering while the receiver stalls hard: queue fills up
        hold_off <= 1'b1;
        fork
            begin
                send_message(2, 1'b0);
                send_message(6, 1'b0);
                stop_send();
            end
            begin repeat (400) @(posedge i_clk); hold_off <= 1'b0; end
        join
        drain();

        // random: pad boundary, block-aligned end, short messages
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 28 : (phase == 1) ? 53 : 0;
            recv_idle = (phase == 0) ? 53 : (phase == 1) ? 28 : 0;
            for (int m = 0; m < 2; m++) begin
                case (phase)
                    0: len = (m == 0) ? $urandom_range(54, 57) : $urandom_range(0, 5);
                    1: len = (m == 0) ? 64 : $urandom_range(0, 5);
                    default: len = $urandom_range(6, 12);
                endcase
                ee = 1'($urandom_range(1));
                if (phase == 1 && m == 0) ee = 1'b0;
                send_message(len, ee);
                if ($urandom_range(3) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
            end
            stop_send();
            drain();
        end
        repeat (400) @(posedge i_clk);

        $display("sent %0d items, %0d digests, %0d words checked",
                 items_sent, board.digests, board.words_seen);
        $display("covered empty, short, pad-boundary and block-aligned messages");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[sha256_stream_hasher_core.f]
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_ram.sv
rtl/sha_back.sv
rtl/sha256_stream_hasher_core.sv
test/sha256_stream_hasher_core_tb.sv
